>>> rtl/gsbc_pkg.sv
// gsbc_pkg: shared constants, types and state encoding for the gyro stillness
// bias calibrator. No dependencies; imported by every other file.
`default_nettype none

package gsbc_pkg;

    // default ring depth and fixed sample width
    localparam int WINDOW_DEF = 100;
    localparam int DATA_W     = 16;

    // stillness threshold after reset
    localparam logic [DATA_W-1:0] DELTA_RST = 16'd131;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } gsbc_state_t;

    // per-lane memory and tracker controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_first;
    } gsbc_lane_ctrl_t;

    // minimum and maximum found by one lane
    typedef struct packed {
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
    } gsbc_span_t;

    // merged result of the three lanes
    typedef struct packed {
        logic                     calibrated;
        logic signed [DATA_W-1:0] offset_x;
        logic signed [DATA_W-1:0] offset_y;
        logic signed [DATA_W-1:0] offset_z;
    } gsbc_res_t;

endpackage

`default_nettype wire

>>> rtl/gsbc_if.sv
// gsbc channel interfaces: gyro sample input and calibration result output.
// Depends on gsbc_pkg for the sample width.
`default_nettype none

interface gsbc_sample_if
    import gsbc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] rate_x;
    logic signed [DATA_W-1:0] rate_y;
    logic signed [DATA_W-1:0] rate_z;

    modport source (output valid, output rate_x, output rate_y, output rate_z,
                    input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z,
                    output ready);
endinterface

interface gsbc_result_if
    import gsbc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     calibrated;
    logic signed [DATA_W-1:0] offset_x;
    logic signed [DATA_W-1:0] offset_y;
    logic signed [DATA_W-1:0] offset_z;

    modport source (output valid, output calibrated, output offset_x,
                    output offset_y, output offset_z, input ready);
    modport sink   (input valid, input calibrated, input offset_x,
                    input offset_y, input offset_z, output ready);
endinterface

`default_nettype wire

>>> rtl/gsbc_lane.sv
// gsbc_lane: one axis of the calibrator, a sample ring memory with a
// registered read port and a running min/max tracker. Depends on gsbc_pkg.
`default_nettype none

module gsbc_lane
    import gsbc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    parameter int AW     = $clog2(WINDOW)
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire gsbc_lane_ctrl_t          ctrl,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic signed [DATA_W-1:0] wr_data,
    input  wire logic [AW-1:0]            rd_addr,
    output gsbc_span_t                    span
);

    logic signed [DATA_W-1:0] mem [WINDOW];
    logic signed [DATA_W-1:0] rdata_reg;
    logic                     vld_reg;
    logic                     first_reg;
    logic signed [DATA_W-1:0] lo_reg;
    logic signed [DATA_W-1:0] hi_reg;
    logic signed [DATA_W-1:0] lo_next;
    logic signed [DATA_W-1:0] hi_next;

    // ring write and registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // read data qualifiers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            vld_reg   <= ctrl.rd_en;
            first_reg <= ctrl.rd_first;
        end
    end

    // min/max update, first entry seeds both
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (vld_reg)
        begin
            if (first_reg || (rdata_reg < lo_reg))
            begin
                lo_next = rdata_reg;
            end
            if (first_reg || (rdata_reg > hi_reg))
            begin
                hi_next = rdata_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign span.lo = lo_reg;
    assign span.hi = hi_reg;

endmodule

`default_nettype wire

>>> rtl/gsbc_merge.sv
// gsbc_merge: combines the three lane spans into the stillness decision and
// the floored midpoint offsets. Depends on gsbc_pkg.
`default_nettype none

module gsbc_merge
    import gsbc_pkg::*;
(
    input  wire gsbc_span_t        span_x,
    input  wire gsbc_span_t        span_y,
    input  wire gsbc_span_t        span_z,
    input  wire logic              scanned,
    input  wire logic [DATA_W-1:0] stable_delta,
    output gsbc_res_t              res
);

    logic signed [DATA_W:0] rng_x, rng_y, rng_z;
    logic signed [DATA_W:0] sum_x, sum_y, sum_z;
    logic                   still;

    // per-axis range and sum, one bit wider so nothing overflows
    always_comb
    begin
        rng_x = {span_x.hi[DATA_W-1], span_x.hi} - {span_x.lo[DATA_W-1], span_x.lo};
        rng_y = {span_y.hi[DATA_W-1], span_y.hi} - {span_y.lo[DATA_W-1], span_y.lo};
        rng_z = {span_z.hi[DATA_W-1], span_z.hi} - {span_z.lo[DATA_W-1], span_z.lo};
        sum_x = {span_x.hi[DATA_W-1], span_x.hi} + {span_x.lo[DATA_W-1], span_x.lo};
        sum_y = {span_y.hi[DATA_W-1], span_y.hi} + {span_y.lo[DATA_W-1], span_y.lo};
        sum_z = {span_z.hi[DATA_W-1], span_z.hi} + {span_z.lo[DATA_W-1], span_z.lo};
    end

    // ranges are never negative, compare unsigned against the threshold
    assign still = scanned
                 && (unsigned'(rng_x) < {1'b0, stable_delta})
                 && (unsigned'(rng_y) < {1'b0, stable_delta})
                 && (unsigned'(rng_z) < {1'b0, stable_delta});

    // arithmetic shift gives the floor of the half sum
    always_comb
    begin
        res.calibrated = still;
        res.offset_x   = '0;
        res.offset_y   = '0;
        res.offset_z   = '0;
        if (still)
        begin
            res.offset_x = sum_x[DATA_W:1];
            res.offset_y = sum_y[DATA_W:1];
            res.offset_z = sum_z[DATA_W:1];
        end
    end

endmodule

`default_nettype wire

>>> rtl/gyro_stillness_bias_calibrator_top.sv
// Before the ring is full, a taken sample goes straight to FINISH, which
// loads the result register; once full, the lanes first scan all WINDOW
// entries in SCAN, one per cycle through each memory's single read port,
// then pass DRAIN. Samples are taken only in IDLE, after the last result
// is loaded. Reset (rst_n, async, active low) clears the ring fill flag,
// zeroes the write slot, sets the threshold to 131, drops any pending result.
`default_nettype none

module gyro_stillness_bias_calibrator_top
    import gsbc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    gsbc_sample_if.sink            sample,
    gsbc_result_if.source          result,
    input  wire logic              cfg_wr_en,
    input  wire logic [DATA_W-1:0] cfg_wr_data
);

    localparam int AW = $clog2(WINDOW);
    localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

    gsbc_state_t       state_reg, state_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [AW-1:0]     scan_cnt_reg, scan_cnt_next;
    logic              full_reg, full_next;
    logic              scanned_reg, scanned_next;
    logic [DATA_W-1:0] delta_reg;
    logic              out_valid_reg, out_valid_next;
    gsbc_res_t         out_reg;
    gsbc_res_t         merged;
    gsbc_lane_ctrl_t   lane_ctrl;
    gsbc_span_t        span_x, span_y, span_z;
    logic              take;
    logic              load;

    assign take = sample.valid && sample.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = full_reg ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        sample.ready       = 1'b0;
        lane_ctrl.wr_en    = 1'b0;
        lane_ctrl.rd_en    = 1'b0;
        lane_ctrl.rd_first = 1'b0;
        load               = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample.ready    = 1'b1;
                lane_ctrl.wr_en = sample.valid;
            end
            ST_SCAN:
            begin
                lane_ctrl.rd_en    = 1'b1;
                lane_ctrl.rd_first = (scan_cnt_reg == '0);
            end
            ST_DRAIN:  load = 1'b0;
            ST_FINISH: load = !out_valid_reg || result.ready;
            default:   load = 1'b0;
        endcase
    end

    // ring pointer, fill flag and scan counter
    always_comb
    begin
        slot_next     = slot_reg;
        full_next     = full_reg;
        scanned_next  = scanned_reg;
        scan_cnt_next = scan_cnt_reg;
        if (take)
        begin
            slot_next     = (slot_reg == LAST) ? '0 : slot_reg + AW'(1);
            full_next     = full_reg || (slot_reg == LAST);
            scanned_next  = full_reg;
            scan_cnt_next = '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_cnt_next = scan_cnt_reg + AW'(1);
        end
    end

    // output register transfer bookkeeping
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            scanned_reg   <= 1'b0;
            scan_cnt_reg  <= '0;
            delta_reg     <= DELTA_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            full_reg      <= full_next;
            scanned_reg   <= scanned_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                delta_reg <= cfg_wr_data;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= merged;
        end
    end

    // one lane per axis
    gsbc_lane #(.WINDOW(WINDOW), .AW(AW)) u_lane_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .wr_addr (slot_reg),
        .wr_data (sample.rate_x),
        .rd_addr (scan_cnt_reg),
        .span    (span_x)
    );

    gsbc_lane #(.WINDOW(WINDOW), .AW(AW)) u_lane_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .wr_addr (slot_reg),
        .wr_data (sample.rate_y),
        .rd_addr (scan_cnt_reg),
        .span    (span_y)
    );

    gsbc_lane #(.WINDOW(WINDOW), .AW(AW)) u_lane_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .wr_addr (slot_reg),
        .wr_data (sample.rate_z),
        .rd_addr (scan_cnt_reg),
        .span    (span_z)
    );

    // combine lane spans
    gsbc_merge u_merge (
        .span_x       (span_x),
        .span_y       (span_y),
        .span_z       (span_z),
        .scanned      (scanned_reg),
        .stable_delta (delta_reg),
        .res          (merged)
    );

    assign result.valid      = out_valid_reg;
    assign result.calibrated = out_reg.calibrated;
    assign result.offset_x   = out_reg.offset_x;
    assign result.offset_y   = out_reg.offset_y;
    assign result.offset_z   = out_reg.offset_z;

endmodule

`default_nettype wire

>>> rtl/gsbc_checker.sv
// gsbc_checker: port-level assertions for the calibrator top, attached by
// bind. Depends on gsbc_pkg and on the top level's port names.
`default_nettype none

module gsbc_checker
    import gsbc_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_ready,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic                     calibrated,
    input wire logic signed [DATA_W-1:0] offset_x,
    input wire logic signed [DATA_W-1:0] offset_y,
    input wire logic signed [DATA_W-1:0] offset_z
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(calibrated)
            && $stable(offset_x) && $stable(offset_y) && $stable(offset_z))
        else $error("result changed while stalled");

    // an uncalibrated result carries zero offsets
    a_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !calibrated |-> offset_x == '0 && offset_y == '0
            && offset_z == '0)
        else $error("nonzero offset without calibration");

    // one sample at a time: input closes right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input open right after a transfer");

    // no result is pending coming out of reset
    a_rst_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind gyro_stillness_bias_calibrator_top gsbc_checker u_gsbc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .calibrated (result.calibrated),
    .offset_x   (result.offset_x),
    .offset_y   (result.offset_y),
    .offset_z   (result.offset_z)
);

`default_nettype wire
